// ===== design/pid_controller_clamped_unit_defines.svh =====
// assertion macros for the pid controller checker
// expects clk and arst_n in the scope that uses them
`ifndef PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_DEFINES_SVH

// checked only while out of reset
`define PCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pcc_pkg.sv =====
// shared widths, register indexes and opcodes of the pid controller
// no dependencies
package pcc_pkg;

	localparam int GAIN_W = 32;
	localparam int ILIM_W = 24;
	localparam int OLIM_W = 31;
	localparam int DATA_W = 16;
	localparam int ERR_W  = DATA_W + 1;
	localparam int DER_W  = ERR_W + 1;
	localparam int INT_W  = ILIM_W + 1;
	localparam int OUT_W  = 32;
	localparam int IDX_W  = 3;
	localparam int FRAC_W = 16;

	localparam int PP_W   = GAIN_W + ERR_W;
	localparam int PI_W   = GAIN_W + INT_W;
	localparam int PD_W   = GAIN_W + DER_W;
	localparam int SUM_W  = PI_W + 1;
	localparam int SHR_W  = SUM_W - FRAC_W;

	typedef enum logic [IDX_W-1:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_ILIM = 3'd3,
		REG_OLIM = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

endpackage

// ===== design/pid_controller_clamped_unit.sv =====
// positional pid controller with integral and output clamps
// depends on pcc_pkg
//
// input channel (in_valid/in_ready) takes one transaction per item: opcode,
// setpoint, measured. output channel (out_valid/out_ready) returns one
// control_out per item, in order. a step item updates the error history and
// the clamped integral, a clear item zeroes the integral and returns the
// last step output.
// gains and limits are written through cfg_we/cfg_index/cfg_data while idle;
// the block does not enforce this, the user must keep to it. an accepted item
// loads the input stage, then the multiply stage, sum stage, output register.
// throughput: one item per cycle while out_ready holds; the integral and previous
// error update in the input stage so items can follow back to back.
// three multipliers of up to 32 x 25 bits work in parallel in one stage.
// reset clears gains, limits, error history, integral and last output, and
// empties the pipeline.
// when the receiver stalls, the pipeline keeps filling behind the output
// register; in_ready drops only once all four stages hold items.
module pid_controller_clamped_unit
	import pcc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic signed [DATA_W-1:0] setpoint,
	input  logic signed [DATA_W-1:0] measured,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  control_out
);

	logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [ILIM_W-1:0]        ilim_q;
	logic [OLIM_W-1:0]        olim_q;

	logic signed [ERR_W-1:0]  prev_q;
	logic signed [INT_W-1:0]  integ_q;
	logic signed [OUT_W-1:0]  last_q;

	logic                     valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                     op_s1, op_s2, op_s3;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DER_W-1:0]  der_s1;
	logic signed [INT_W-1:0]  int_s1;
	logic signed [PP_W-1:0]   pp_s2;
	logic signed [PI_W-1:0]   pi_s2;
	logic signed [PD_W-1:0]   pd_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [OUT_W-1:0]  out_q;

	logic adv1, adv2, adv3, adv_out, accept;

	logic signed [ERR_W-1:0]  err;
	logic signed [DER_W-1:0]  der;
	logic signed [INT_W:0]    isum, ilim_p, ilim_n;
	logic signed [INT_W-1:0]  iclamp;
	logic signed [PP_W-1:0]   pp;
	logic signed [PI_W-1:0]   pi;
	logic signed [PD_W-1:0]   pd;
	logic signed [SHR_W-1:0]  shr, olim_p, olim_n;
	logic signed [OUT_W-1:0]  oclamp;

	// pipeline flow control
	assign adv_out = !out_valid_q || out_ready;
	assign adv3    = !valid_s3 || adv_out;
	assign adv2    = !valid_s2 || adv3;
	assign adv1    = !valid_s1 || adv2;
	assign in_ready  = adv1;
	assign accept    = in_valid && adv1;
	assign out_valid = out_valid_q;
	assign control_out = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			ilim_q <= '0;
			olim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:   kp_q   <= cfg_data;
				REG_KI:   ki_q   <= cfg_data;
				REG_KD:   kd_q   <= cfg_data;
				REG_ILIM: ilim_q <= cfg_data[ILIM_W-1:0];
				REG_OLIM: olim_q <= cfg_data[OLIM_W-1:0];
				default:  ;
			endcase
		end
	end

	// stage 1: error, derivative, clamped integral
	always_comb begin
		err    = ERR_W'(setpoint) - ERR_W'(measured);
		der    = DER_W'(err) - DER_W'(prev_q);
		isum   = (INT_W+1)'(integ_q) + (INT_W+1)'(err);
		ilim_p = signed'((INT_W+1)'(ilim_q));
		ilim_n = -ilim_p;
		if (isum > ilim_p) begin
			iclamp = INT_W'(ilim_p);
		end else if (isum < ilim_n) begin
			iclamp = INT_W'(ilim_n);
		end else begin
			iclamp = INT_W'(isum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (accept) begin
			if (opcode == OP_CLEAR) begin
				integ_q <= '0;
			end else begin
				prev_q  <= err;
				integ_q <= iclamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			err_s1 <= err;
			der_s1 <= der;
			int_s1 <= iclamp;
		end
	end

	// stage 2: gain products
	always_comb begin
		pp = PP_W'(err_s1) * PP_W'(kp_q);
		pi = PI_W'(int_s1) * PI_W'(ki_q);
		pd = PD_W'(der_s1) * PD_W'(kd_q);
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			op_s2 <= op_s1;
			pp_s2 <= pp;
			pi_s2 <= pi;
			pd_s2 <= pd;
		end
	end

	// stage 3: product sum
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			op_s3  <= op_s2;
			sum_s3 <= SUM_W'(pp_s2) + SUM_W'(pi_s2) + SUM_W'(pd_s2);
		end
	end

	// output stage: floor shift and output clamp
	always_comb begin
		shr    = sum_s3[SUM_W-1:FRAC_W];
		olim_p = signed'(SHR_W'(olim_q));
		olim_n = -olim_p;
		if (shr > olim_p) begin
			oclamp = OUT_W'(olim_p);
		end else if (shr < olim_n) begin
			oclamp = OUT_W'(olim_n);
		end else begin
			oclamp = OUT_W'(shr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (adv_out && valid_s3 && op_s3 == OP_STEP) begin
			last_q <= oclamp;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s3) begin
			out_q <= (op_s3 == OP_CLEAR) ? last_q : oclamp;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1)    valid_s1    <= in_valid;
			if (adv2)    valid_s2    <= valid_s1;
			if (adv3)    valid_s3    <= valid_s2;
			if (adv_out) out_valid_q <= valid_s3;
		end
	end

endmodule

// ===== design/pcc_checker.sv =====
// port-level checker for the pid controller, bound to the top level
// depends on pcc_pkg and pid_controller_clamped_unit_defines.svh
`include "pid_controller_clamped_unit_defines.svh"

module pcc_checker
	import pcc_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [OUT_W-1:0]  control_out
);

	logic [2:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	`PCC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(control_out), "output changed while stalled")
	`PCC_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "output valid right after reset")
	`PCC_ASSERT(a_no_phantom, out_valid |-> pending_q != 3'd0, "output without a pending transaction")
	`PCC_ASSERT(a_ready_full, !in_ready |-> out_valid && !out_ready && pending_q == 3'd4, "input stalled while pipeline has room")
	`PCC_ASSERT(a_out_range, out_valid |-> control_out != {1'b1, {(OUT_W-1){1'b0}}}, "output outside symmetric range")

endmodule

bind pid_controller_clamped_unit pcc_checker u_pcc_checker (.*);

// ===== test/pid_controller_clamped_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for pid_controller_clamped_unit: directed table, then random phases
// depends on pcc_pkg and the pid_controller_clamped_unit rtl
module pid_controller_clamped_unit_test;
	import pcc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_TAIL  = 8;
	localparam int BLOCKS      = 20;
	localparam int BLOCK_ITEMS = 96;

	typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

	typedef struct {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [ILIM_W-1:0] ilim;
		logic [OLIM_W-1:0] olim;
	} gain_set_t;

	typedef struct {
		int      ph;
		opcode_t op;
		int      sp;
		int      ms;
		bit      chk;
		int      expv;
	} probe_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [GAIN_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic                     opcode;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] measured;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [OUT_W-1:0]  control_out;

	// predictor copy of the controller state and registers
	logic signed [ERR_W-1:0]  err_hist = '0;
	logic signed [INT_W-1:0]  err_sum  = '0;
	logic signed [OUT_W-1:0]  out_hist = '0;
	logic signed [GAIN_W-1:0] gain_p   = '0;
	logic signed [GAIN_W-1:0] gain_i   = '0;
	logic signed [GAIN_W-1:0] gain_d   = '0;
	logic [ILIM_W-1:0]        lim_int  = '0;
	logic [OLIM_W-1:0]        lim_out  = '0;

	logic signed [OUT_W-1:0] control_expected [$];
	pace_t pace = PACE_LIGHT;
	int    mismatch_count = 0;
	int    results_seen = 0;
	int    step_count = 0;
	int    clear_count = 0;
	int    config_count = 0;
	int    cycle_count = 0;

	gain_set_t probe_cfg [8] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0000, 31'h0000_0000},
		'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 31'h7FFF_FFFF},
		'{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 24'd100,     31'h7FFF_FFFF},
		'{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 24'd10,      31'h7FFF_FFFF},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_8000, 24'h00_0000, 31'h7FFF_FFFF},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 31'd1000},
		'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h00_0000, 31'h0000_0000},
		'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF}
	};

	probe_row_t probe_rows [25] = '{
		// reset values: every output clamps to zero
		'{0, OP_STEP,   32767, -32768, 1, 0},
		'{0, OP_STEP,  -32768,  32767, 1, 0},
		'{0, OP_CLEAR,      0,      0, 1, 0},
		// unity proportional gain
		'{1, OP_STEP,   32767, -32768, 1, 65535},
		'{1, OP_STEP,  -32768,  32767, 1, -65535},
		'{1, OP_STEP,       0,      0, 1, 0},
		'{1, OP_STEP,    1234,    234, 1, 1000},
		'{1, OP_CLEAR,      5,      6, 1, 1000},
		// unity integral gain, integral clamp at 100
		'{2, OP_STEP,    1000,      0, 1, 100},
		'{2, OP_STEP,     -50,      0, 1, 50},
		'{2, OP_CLEAR,      0,      0, 1, 50},
		'{2, OP_STEP,  -32768,  32767, 1, -100},
		// integral limit lowered while the sum sits at -100
		'{3, OP_STEP,       3,      0, 1, -10},
		'{3, OP_STEP,       0,      0, 1, -10},
		// half derivative gain, floor rounding
		'{4, OP_STEP,     500,      0, 1, 250},
		'{4, OP_STEP,     500,      0, 1, 0},
		'{4, OP_STEP,  -32768,  32767, 1, -33018},
		'{4, OP_STEP,   32767, -32768, 1, 65535},
		// extreme gains against a small output limit
		'{5, OP_STEP,   32767, -32768, 0, 0},
		'{5, OP_STEP,  -32768,  32767, 0, 0},
		'{5, OP_STEP,      12,      7, 0, 0},
		// zero output limit
		'{6, OP_STEP,     100,      0, 1, 0},
		'{6, OP_CLEAR,      0,      0, 1, 0},
		// extreme gains, no clamp on the integral
		'{7, OP_STEP,  -32768,  32767, 0, 0},
		'{7, OP_STEP,   32767, -32768, 0, 0}
	};

	pid_controller_clamped_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.setpoint    (setpoint),
		.measured    (measured),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.control_out (control_out)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				control_expected.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap(pace_t p);
		case (p)
			PACE_FULL:  return 0;
			PACE_LIGHT: return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
			default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60)
				: $urandom_range(0, 4);
		endcase
	endfunction

	// advances the controller state by one item and returns its output
	function automatic logic signed [OUT_W-1:0] pid_advance(opcode_t op,
		logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] ms);
		longint e;
		longint d;
		longint acc;
		longint lim;
		if (op == OP_CLEAR) begin
			err_sum = '0;
		end else begin
			e = longint'(sp) - longint'(ms);
			d = e - longint'(err_hist);
			err_hist = e[ERR_W-1:0];
			acc = longint'(err_sum) + e;
			lim = longint'(lim_int);
			if (acc > lim) acc = lim;
			else if (acc < -lim) acc = -lim;
			err_sum = acc[INT_W-1:0];
			acc = longint'(gain_p) * e + longint'(gain_i) * longint'(err_sum)
				+ longint'(gain_d) * d;
			acc = acc >>> FRAC_W;
			lim = longint'(lim_out);
			if (acc > lim) acc = lim;
			else if (acc < -lim) acc = -lim;
			out_hist = acc[OUT_W-1:0];
		end
		return out_hist;
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 3))
			0: return $urandom;
			3: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 1 << 19) - (1 << 18);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_sample();
		case ($urandom_range(0, 3))
			2: return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
			3: return DATA_W'($urandom_range(0, 200) - 100);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// waits until every expected result has come back, then lets the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (control_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t r, logic [GAIN_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	task automatic reconfigure(gain_set_t s);
		drain();
		cfg_write(REG_KP, s.kp);
		cfg_write(REG_KI, s.ki);
		cfg_write(REG_KD, s.kd);
		cfg_write(REG_ILIM, GAIN_W'(s.ilim));
		cfg_write(REG_OLIM, GAIN_W'(s.olim));
		cfg_we  <= 1'b0;
		gain_p  = s.kp;
		gain_i  = s.ki;
		gain_d  = s.kd;
		lim_int = s.ilim;
		lim_out = s.olim;
		config_count++;
	endtask

	task automatic send_item(opcode_t op, logic signed [DATA_W-1:0] sp,
		logic signed [DATA_W-1:0] ms, bit chk, logic signed [OUT_W-1:0] expv);
		int gap;
		logic signed [OUT_W-1:0] pred;
		gap = pick_gap(pace);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		setpoint <= sp;
		measured <= ms;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		pred = pid_advance(op, sp, ms);
		control_expected.push_back(chk ? expv : pred);
		if (op == OP_CLEAR) clear_count++;
		else step_count++;
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = pick_gap(pace);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(negedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (control_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transaction: control_out %0d", control_out);
			end else begin
				want = control_expected.pop_front();
				if (control_out !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("control_out mismatch on result %0d: expected %0d, got %0d",
							results_seen, want, control_out);
				end
			end
		end
	end

	initial begin
		int cur_ph;
		gain_set_t s;
		opcode_t op;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_KP;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_STEP;
		setpoint  <= '0;
		measured  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_ph = 0;
		foreach (probe_rows[i]) begin
			if (probe_rows[i].ph != cur_ph) begin
				cur_ph = probe_rows[i].ph;
				reconfigure(probe_cfg[cur_ph]);
			end
			send_item(probe_rows[i].op, DATA_W'(probe_rows[i].sp), DATA_W'(probe_rows[i].ms),
				probe_rows[i].chk, probe_rows[i].expv);
		end

		for (int blk = 0; blk < BLOCKS; blk++) begin
			s.kp = rand_gain();
			s.ki = rand_gain();
			s.kd = rand_gain();
			case ($urandom_range(0, 3))
				0: s.ilim = '0;
				1: s.ilim = '1;
				2: s.ilim = ILIM_W'($urandom_range(0, 2000));
				default: s.ilim = ILIM_W'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: s.olim = '0;
				1: s.olim = '1;
				2, 3, 4: s.olim = OLIM_W'($urandom_range(0, 100000));
				default: s.olim = OLIM_W'($urandom);
			endcase
			pace = pace_t'(blk % 3);
			reconfigure(s);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				if ($urandom_range(0, 199) == 0)
					drain();
				op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_STEP;
				send_item(op, rand_sample(), rand_sample(), 1'b0, '0);
			end
		end
		drain();

		$display("%0d step and %0d clear transactions over %0d register settings",
			step_count, clear_count, config_count);
		$display("%0d results checked in %0d cycles, %0d mismatches",
			results_seen, cycle_count, mismatch_count);
		if (mismatch_count == 0 && control_expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
